>>> hw/rtl/zot_pkg.sv
// ----------------------------------------------------------------------------
// zot_pkg
// Shared types, codes and helpers of the zone outline tracer.
// ----------------------------------------------------------------------------
package zot_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int AddrW     = 16;
  localparam int CoordW    = 10;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_FETCH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  localparam logic [1:0] KindVertex = 2'd0;
  localparam logic [1:0] KindFirst  = 2'd1;
  localparam logic [1:0] KindDone   = 2'd2;

  typedef enum logic [2:0] {
    PR_HERE,
    PR_LEFT,
    PR_UP,
    PR_RIGHT_HAND,
    PR_AHEAD
  } probe_e;

  typedef enum logic [1:0] {
    EM_FIRST,
    EM_VERTEX,
    EM_HELD,
    EM_DONE
  } emit_e;

  typedef struct packed {
    logic   wr_pixel;
    logic   start;
    logic   clear_step;
    logic   probe;
    probe_e probe_sel;
    logic   load_scan;
    logic   scan_adv;
    logic   adv_end_row;
    logic   dec_x;
    logic   dec_y;
    logic   load_walk;
    logic   turn_right;
    logic   turn_left;
    logic   step;
    logic   emit;
    emit_e  emit_sel;
  } zot_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       col_ge_w;
    logic       adv_last;
    logic       black;
    logic       visited;
    logic       clear_done;
    logic       held_valid;
    logic [1:0] n_verts;
    logic       ahead_inside;
  } zot_status_t;

  // Unit steps for the four headings: +x, +y, -x, -y.
  function automatic coord_t dir_dx(input logic [1:0] d);
    coord_t r;
    unique case (d)
      2'd0:    r = 10'sd1;
      2'd2:    r = -10'sd1;
      default: r = 10'sd0;
    endcase
    return r;
  endfunction

  function automatic coord_t dir_dy(input logic [1:0] d);
    coord_t r;
    unique case (d)
      2'd1:    r = 10'sd1;
      2'd3:    r = -10'sd1;
      default: r = 10'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/zone_outline_tracer.sv
// ----------------------------------------------------------------------------
// zone_outline_tracer
// Traces the outlines of colored zones in a 256 x 256 RGB frame store.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+----------------------
//  in       | in_valid_i, in_stall_o, op_i, pixel/color | write, start, fetch
//  out      | out_valid_o, out_stall_i, kind_o, vertex  | one vertex per fetch
//  cfg      | cfg_we_i, cfg_index_i, cfg_data_i         | image width, height
//
// A start sweeps the visited map one entry per cycle, all 65536 entries, with
// the input stalled. A fetch walks the scan and trace with one frame store
// probe at a time, each probe followed by an evaluate state (single read port,
// registered read); its length depends on the image. Reset leaves the scan
// idle, so a fetch before the first start answers scan finished. A fetch is
// stalled while the previous result has not been taken; other transfers are
// not.
module zone_outline_tracer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [7:0]        pixel_x_i,
  input  logic [7:0]        pixel_y_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic signed [9:0] vertex_x_o,
  output logic signed [9:0] vertex_y_o,
  output logic [7:0]        zone_red_o,
  output logic [7:0]        zone_green_o,
  output logic [7:0]        zone_blue_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [8:0]        cfg_data_i
);

  zot_pkg::zot_cmd_t    cmd;
  zot_pkg::zot_status_t status;

  zot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  zot_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .kind_o       (kind_o),
    .vertex_x_o   (vertex_x_o),
    .vertex_y_o   (vertex_y_o),
    .zone_red_o   (zone_red_o),
    .zone_green_o (zone_green_o),
    .zone_blue_o  (zone_blue_o)
  );

endmodule

>>> hw/rtl/zot_datapath.sv
// ----------------------------------------------------------------------------
// zot_datapath
// Frame store, visited map, scan and walk pointers, vertex and result regs.
// ----------------------------------------------------------------------------
module zot_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  zot_pkg::zot_cmd_t   cmd_i,
  output zot_pkg::zot_status_t status_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [8:0]          cfg_data_i,
  input  logic [7:0]          pixel_x_i,
  input  logic [7:0]          pixel_y_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic [1:0]          kind_o,
  output logic signed [9:0]   vertex_x_o,
  output logic signed [9:0]   vertex_y_o,
  output logic [7:0]          zone_red_o,
  output logic [7:0]          zone_green_o,
  output logic [7:0]          zone_blue_o
);

  logic [23:0] frame_mem [2**zot_pkg::AddrW];
  logic        vis_mem   [2**zot_pkg::AddrW];

  logic [8:0]  width_q, height_q, eff_w, eff_h;
  logic [7:0]  scan_col_q, scan_row_q, walk_col_q, walk_row_q, cur_x_q, cur_y_q;
  logic [1:0]  heading_q, n_q;
  logic [23:0] zone_q, rd_color_q;
  logic        rd_vis_q, inside_q, held_valid_q;
  zot_pkg::coord_t vtx0_x_q, vtx0_y_q, vtx1_x_q, vtx1_y_q, held_x_q, held_y_q;
  logic [zot_pkg::AddrW-1:0] clr_q;

  zot_pkg::coord_t off_x, off_y, px, py, cx, cy, dx, dy, rx, ry, lx, ly;
  logic        in_range, col_inc_ok, row_inc_ok;
  logic [zot_pkg::AddrW-1:0] probe_addr;

  assign eff_w = (width_q > 9'(zot_pkg::MaxWidth)) ? 9'(zot_pkg::MaxWidth) : width_q;
  assign eff_h = (height_q > 9'(zot_pkg::MaxHeight)) ? 9'(zot_pkg::MaxHeight) : height_q;

  assign cx = $signed({2'b00, cur_x_q});
  assign cy = $signed({2'b00, cur_y_q});
  assign dx = zot_pkg::dir_dx(heading_q);
  assign dy = zot_pkg::dir_dy(heading_q);

  always_comb begin
    case (cmd_i.probe_sel)
      zot_pkg::PR_LEFT: begin
        off_x = -10'sd1;
        off_y = 10'sd0;
      end
      zot_pkg::PR_UP: begin
        off_x = 10'sd0;
        off_y = -10'sd1;
      end
      zot_pkg::PR_RIGHT_HAND: begin
        off_x = zot_pkg::dir_dx(heading_q + 2'd3);
        off_y = zot_pkg::dir_dy(heading_q + 2'd3);
      end
      zot_pkg::PR_AHEAD: begin
        off_x = dx;
        off_y = dy;
      end
      default: begin
        off_x = 10'sd0;
        off_y = 10'sd0;
      end
    endcase
  end

  assign px = cx + off_x;
  assign py = cy + off_y;
  assign in_range = (px >= 10'sd0) && (py >= 10'sd0) &&
                    (px < $signed({1'b0, eff_w})) && (py < $signed({1'b0, eff_h}));
  assign probe_addr = {py[7:0], px[7:0]};

  // Corner vertices for a right turn (old heading) and a left turn.
  assign rx = cx - dx + dy;
  assign ry = cy - dx - dy;
  assign lx = cx + dx + dy;
  assign ly = cy - dx + dy;

  assign col_inc_ok = !cmd_i.adv_end_row && ((9'(scan_col_q) + 9'd1) < eff_w);
  assign row_inc_ok = (9'(scan_row_q) + 9'd1) < eff_h;

  assign status_o.empty        = (eff_w == 9'd0) || (eff_h == 9'd0) ||
                                 ({1'b0, scan_row_q} >= eff_h);
  assign status_o.col_ge_w     = {1'b0, scan_col_q} >= eff_w;
  assign status_o.adv_last     = !col_inc_ok && !row_inc_ok;
  assign status_o.black        = !inside_q || (rd_color_q == 24'd0);
  assign status_o.visited      = !inside_q || rd_vis_q;
  assign status_o.clear_done   = &clr_q;
  assign status_o.held_valid   = held_valid_q;
  assign status_o.n_verts      = n_q;
  assign status_o.ahead_inside = in_range;

  // Memories: one write port each, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pixel) begin
      frame_mem[{pixel_y_i, pixel_x_i}] <= {red_i, green_i, blue_i};
    end
    if (cmd_i.probe) begin
      rd_color_q <= frame_mem[probe_addr];
      rd_vis_q   <= vis_mem[probe_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      vis_mem[clr_q] <= 1'b0;
    end else if (cmd_i.step) begin
      vis_mem[{cur_y_q, cur_x_q}] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= 9'd256;
      height_q     <= 9'd256;
      scan_col_q   <= '0;
      scan_row_q   <= '0;
      walk_col_q   <= '0;
      walk_row_q   <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      heading_q    <= '0;
      n_q          <= '0;
      zone_q       <= '0;
      held_valid_q <= 1'b0;
      inside_q     <= 1'b0;
      clr_q        <= '0;
      vtx0_x_q     <= '0;
      vtx0_y_q     <= '0;
      vtx1_x_q     <= '0;
      vtx1_y_q     <= '0;
      held_x_q     <= '0;
      held_y_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i) begin
          height_q <= cfg_data_i;
        end else begin
          width_q <= cfg_data_i;
        end
      end
      if (cmd_i.probe) begin
        inside_q <= in_range;
      end
      if (cmd_i.start) begin
        scan_col_q   <= '0;
        scan_row_q   <= '0;
        walk_col_q   <= '0;
        walk_row_q   <= '0;
        heading_q    <= '0;
        zone_q       <= '0;
        held_valid_q <= 1'b0;
        clr_q        <= '0;
      end
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.load_scan) begin
        cur_x_q <= scan_col_q;
        cur_y_q <= scan_row_q;
      end
      if (cmd_i.scan_adv) begin
        if (col_inc_ok) begin
          scan_col_q <= scan_col_q + 8'd1;
        end else begin
          scan_col_q <= '0;
          if (row_inc_ok) begin
            scan_row_q <= scan_row_q + 8'd1;
          end
        end
      end
      if (cmd_i.dec_x) begin
        cur_x_q <= cur_x_q - 8'd1;
      end
      if (cmd_i.dec_y) begin
        cur_y_q <= cur_y_q - 8'd1;
      end
      if (cmd_i.load_walk) begin
        cur_x_q <= walk_col_q;
        cur_y_q <= walk_row_q;
        n_q     <= '0;
      end
      if (cmd_i.turn_right || cmd_i.turn_left) begin
        if (n_q == 2'd0) begin
          vtx0_x_q <= cmd_i.turn_right ? rx : lx;
          vtx0_y_q <= cmd_i.turn_right ? ry : ly;
        end else begin
          vtx1_x_q <= cmd_i.turn_right ? rx : lx;
          vtx1_y_q <= cmd_i.turn_right ? ry : ly;
        end
        n_q       <= n_q + 2'd1;
        heading_q <= cmd_i.turn_right ? heading_q + 2'd3 : heading_q + 2'd1;
      end
      if (cmd_i.step) begin
        if (in_range) begin
          walk_col_q <= px[7:0];
          walk_row_q <= py[7:0];
        end
        if (n_q == 2'd2) begin
          held_x_q     <= vtx1_x_q;
          held_y_q     <= vtx1_y_q;
          held_valid_q <= 1'b1;
        end
      end
      if (cmd_i.emit && cmd_i.emit_sel == zot_pkg::EM_FIRST) begin
        walk_col_q <= cur_x_q;
        walk_row_q <= cur_y_q;
        heading_q  <= '0;
        zone_q     <= rd_color_q;
      end
      if (cmd_i.emit && cmd_i.emit_sel == zot_pkg::EM_HELD) begin
        held_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.emit_sel)
        zot_pkg::EM_FIRST: begin
          kind_o     <= zot_pkg::KindFirst;
          vertex_x_o <= cx - 10'sd1;
          vertex_y_o <= cy - 10'sd1;
          {zone_red_o, zone_green_o, zone_blue_o} <= rd_color_q;
        end
        zot_pkg::EM_VERTEX: begin
          kind_o     <= zot_pkg::KindVertex;
          vertex_x_o <= vtx0_x_q;
          vertex_y_o <= vtx0_y_q;
          {zone_red_o, zone_green_o, zone_blue_o} <= zone_q;
        end
        zot_pkg::EM_HELD: begin
          kind_o     <= zot_pkg::KindVertex;
          vertex_x_o <= held_x_q;
          vertex_y_o <= held_y_q;
          {zone_red_o, zone_green_o, zone_blue_o} <= zone_q;
        end
        default: begin
          kind_o     <= zot_pkg::KindDone;
          vertex_x_o <= '0;
          vertex_y_o <= '0;
          {zone_red_o, zone_green_o, zone_blue_o} <= '0;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/zot_ctrl.sv
// ----------------------------------------------------------------------------
// zot_ctrl
// Sequencer for loads, the visited-map clear, and the scan and trace walk.
// ----------------------------------------------------------------------------
module zot_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output zot_pkg::zot_cmd_t    cmd_o,
  input  zot_pkg::zot_status_t status_i
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SCAN,
    PH_TRACE,
    PH_TRACE_LAST,
    PH_DONE
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_TOP,
    S_P_PIX, S_E_PIX, S_P_L, S_E_L, S_P_U, S_E_U, S_P_U2, S_E_U2,
    S_P_ORG, S_E_ORG, S_P_TV, S_E_TV, S_P_R, S_E_R, S_P_A, S_E_A, S_STEP
  } state_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   last_q, last_d, left_q, left_d, out_valid_q, out_valid_d, in_acc;

  assign in_stall_o  = (state_q != S_IDLE) ||
                       ((zot_pkg::op_e'(op_i) == zot_pkg::OP_FETCH) && out_valid_q);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    phase_d     = phase_q;
    last_d      = last_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (zot_pkg::op_e'(op_i))
            zot_pkg::OP_WRITE: cmd_o.wr_pixel = 1'b1;
            zot_pkg::OP_START: begin
              cmd_o.start = 1'b1;
              state_d     = S_CLEAR;
            end
            zot_pkg::OP_FETCH: begin
              if (status_i.held_valid) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_sel = zot_pkg::EM_HELD;
                out_valid_d    = 1'b1;
              end else begin
                state_d = S_TOP;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) begin
          phase_d = PH_SCAN;
          state_d = S_IDLE;
        end
      end
      S_TOP: begin
        unique case (phase_q) inside
          PH_SCAN: begin
            if (status_i.empty) begin
              phase_d = PH_DONE;
            end else if (status_i.col_ge_w) begin
              cmd_o.scan_adv    = 1'b1;
              cmd_o.adv_end_row = 1'b1;
              if (status_i.adv_last) begin
                phase_d = PH_DONE;
              end
            end else begin
              cmd_o.load_scan = 1'b1;
              cmd_o.scan_adv  = 1'b1;
              last_d          = status_i.adv_last;
              state_d         = S_P_PIX;
            end
          end
          PH_TRACE, PH_TRACE_LAST: begin
            cmd_o.load_walk = 1'b1;
            state_d         = S_P_TV;
          end
          default: begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = zot_pkg::EM_DONE;
            out_valid_d    = 1'b1;
            if (phase_q != PH_IDLE) begin
              phase_d = PH_DONE;
            end
            state_d = S_IDLE;
          end
        endcase
      end
      S_P_PIX: begin
        cmd_o.probe = 1'b1;
        state_d     = S_E_PIX;
      end
      S_E_PIX: begin
        if (status_i.black) begin
          if (last_q) begin
            phase_d = PH_DONE;
          end
          state_d = S_TOP;
        end else begin
          state_d = S_P_L;
        end
      end
      // Walk left and up to the zone origin.
      S_P_L: begin
        cmd_o.probe     = 1'b1;
        cmd_o.probe_sel = zot_pkg::PR_LEFT;
        state_d         = S_E_L;
      end
      S_E_L: begin
        left_d  = status_i.black;
        state_d = S_P_U;
      end
      S_P_U: begin
        cmd_o.probe     = 1'b1;
        cmd_o.probe_sel = zot_pkg::PR_UP;
        state_d         = S_E_U;
      end
      S_E_U: begin
        if (left_q && status_i.black) begin
          state_d = S_P_ORG;
        end else begin
          cmd_o.dec_x = !left_q;
          state_d     = S_P_U2;
        end
      end
      S_P_U2: begin
        cmd_o.probe     = 1'b1;
        cmd_o.probe_sel = zot_pkg::PR_UP;
        state_d         = S_E_U2;
      end
      S_E_U2: begin
        cmd_o.dec_y = !status_i.black;
        state_d     = S_P_L;
      end
      S_P_ORG: begin
        cmd_o.probe = 1'b1;
        state_d     = S_E_ORG;
      end
      S_E_ORG: begin
        if (status_i.visited) begin
          if (last_q) begin
            phase_d = PH_DONE;
          end
          state_d = S_TOP;
        end else begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = zot_pkg::EM_FIRST;
          out_valid_d    = 1'b1;
          phase_d        = last_q ? PH_TRACE_LAST : PH_TRACE;
          state_d        = S_IDLE;
        end
      end
      // One step of the edge trace.
      S_P_TV: begin
        cmd_o.probe = 1'b1;
        state_d     = S_E_TV;
      end
      S_E_TV: begin
        if (status_i.visited) begin
          phase_d = (phase_q == PH_TRACE_LAST) ? PH_DONE : PH_SCAN;
          state_d = S_TOP;
        end else begin
          state_d = S_P_R;
        end
      end
      S_P_R: begin
        cmd_o.probe     = 1'b1;
        cmd_o.probe_sel = zot_pkg::PR_RIGHT_HAND;
        state_d         = S_E_R;
      end
      S_E_R: begin
        cmd_o.turn_right = !status_i.black;
        state_d          = S_P_A;
      end
      S_P_A: begin
        cmd_o.probe     = 1'b1;
        cmd_o.probe_sel = zot_pkg::PR_AHEAD;
        state_d         = S_E_A;
      end
      S_E_A: begin
        cmd_o.turn_left = status_i.black;
        state_d         = S_STEP;
      end
      S_STEP: begin
        cmd_o.step      = 1'b1;
        cmd_o.probe_sel = zot_pkg::PR_AHEAD;
        if (!status_i.ahead_inside) begin
          phase_d = (phase_q == PH_TRACE_LAST) ? PH_DONE : PH_SCAN;
        end
        if (status_i.n_verts != 2'd0) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = zot_pkg::EM_VERTEX;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_TOP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      last_q      <= 1'b0;
      left_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      last_q      <= last_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the zone outline tracer. It loads small frames and
// a full-width strip, starts an analysis and fetches vertices until the scan
// reports finished. Every result is compared with an in-bench outline
// predictor. Both channels idle and stall at random, with one long output
// hold that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic [1:0]      kind;
    zot_pkg::coord_t vx;
    zot_pkg::coord_t vy;
    logic [7:0]      r;
    logic [7:0]      g;
    logic [7:0]      b;
  } vertex_t;

  typedef enum int {TR_IDLE, TR_SCAN, TR_WALK, TR_WALK_LAST, TR_DONE} trace_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        op_i;
  logic [7:0]        pixel_x_i, pixel_y_i, red_i, green_i, blue_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        kind_o;
  logic signed [9:0] vertex_x_o, vertex_y_o;
  logic [7:0]        zone_red_o, zone_green_o, zone_blue_o;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [8:0]        cfg_data_i;

  zone_outline_tracer u_dut (.*);

  initial forever #10 clk_i = ~clk_i;

  // Outline predictor state.
  logic [23:0] frame_mem [65536];
  bit          seen_mem  [65536];
  int          reg_w = 256, reg_h = 256;
  int          scan_c, scan_r, walk_c, walk_r, head;
  trace_e      tr_state = TR_IDLE;
  logic [23:0] zone_rgb;
  bit          held_ok;
  int          held_x, held_y;
  int          step_x [4] = '{1, 0, -1, 0};
  int          step_y [4] = '{0, 1, 0, -1};

  vertex_t     vertex_q [$];
  logic [1:0]  last_kind;
  int          errors, fetches, outlines, writes_done;
  bit          no_idle;
  int          rx_hold, rx_gap;
  bit          rx_hold_on;

  function automatic int eff_w();
    return (reg_w > zot_pkg::MaxWidth) ? zot_pkg::MaxWidth : reg_w;
  endfunction

  function automatic int eff_h();
    return (reg_h > zot_pkg::MaxHeight) ? zot_pkg::MaxHeight : reg_h;
  endfunction

  function automatic bit in_image(int x, int y);
    return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
  endfunction

  function automatic bit is_black(int x, int y);
    if (!in_image(x, y)) return 1'b1;
    return frame_mem[y * 256 + x] == 24'd0;
  endfunction

  function automatic bit is_seen(int x, int y);
    if (!in_image(x, y)) return 1'b1;
    return seen_mem[y * 256 + x];
  endfunction

  function automatic vertex_t make_vertex(logic [1:0] k, int x, int y, logic [23:0] c);
    vertex_t v;
    v.kind = k;
    v.vx   = zot_pkg::coord_t'(x);
    v.vy   = zot_pkg::coord_t'(y);
    {v.r, v.g, v.b} = c;
    return v;
  endfunction

  // Moves the scan pointer on; returns 1 when the raster is used up.
  function automatic bit scan_step(bit end_row);
    if (!end_row && scan_c + 1 < eff_w()) begin
      scan_c++;
      return 1'b0;
    end
    scan_c = 0;
    if (scan_r + 1 < eff_h()) begin
      scan_r++;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic vertex_t trace_fetch();
    int x, y, nx, ny, n, d, r;
    int vxs [2];
    int vys [2];
    bit last;
    if (held_ok) begin
      held_ok = 1'b0;
      return make_vertex(zot_pkg::KindVertex, held_x, held_y, zone_rgb);
    end
    forever begin
      if (tr_state == TR_SCAN) begin
        if (eff_w() == 0 || eff_h() == 0 || scan_r >= eff_h()) begin
          tr_state = TR_DONE;
          continue;
        end
        if (scan_c >= eff_w()) begin
          if (scan_step(1'b1)) tr_state = TR_DONE;
          continue;
        end
        x = scan_c;
        y = scan_r;
        last = scan_step(1'b0);
        if (is_black(x, y)) begin
          if (last) tr_state = TR_DONE;
          continue;
        end
        // Slide to the zone origin, the top-left reachable corner.
        while (!is_black(x - 1, y) || !is_black(x, y - 1)) begin
          if (!is_black(x - 1, y)) x--;
          if (!is_black(x, y - 1)) y--;
        end
        if (is_seen(x, y)) begin
          if (last) tr_state = TR_DONE;
          continue;
        end
        walk_c = x;
        walk_r = y;
        head = 0;
        zone_rgb = frame_mem[y * 256 + x];
        tr_state = last ? TR_WALK_LAST : TR_WALK;
        return make_vertex(zot_pkg::KindFirst, x - 1, y - 1, zone_rgb);
      end else if (tr_state == TR_WALK || tr_state == TR_WALK_LAST) begin
        x = walk_c;
        y = walk_r;
        d = head;
        n = 0;
        if (is_seen(x, y)) begin
          tr_state = (tr_state == TR_WALK_LAST) ? TR_DONE : TR_SCAN;
          continue;
        end
        r = (d + 3) % 4;
        if (!is_black(x + step_x[r], y + step_y[r])) begin
          vxs[n] = x - step_x[d] + step_y[d];
          vys[n] = y - step_x[d] - step_y[d];
          n++;
          d = r;
        end
        if (is_black(x + step_x[d], y + step_y[d])) begin
          vxs[n] = x + step_x[d] + step_y[d];
          vys[n] = y - step_x[d] + step_y[d];
          n++;
          d = (d + 1) % 4;
        end
        seen_mem[y * 256 + x] = 1'b1;
        head = d;
        nx = x + step_x[d];
        ny = y + step_y[d];
        if (in_image(nx, ny)) begin
          walk_c = nx;
          walk_r = ny;
        end else begin
          tr_state = (tr_state == TR_WALK_LAST) ? TR_DONE : TR_SCAN;
        end
        if (n == 2) begin
          held_ok = 1'b1;
          held_x = vxs[1];
          held_y = vys[1];
        end
        if (n > 0) return make_vertex(zot_pkg::KindVertex, vxs[0], vys[0], zone_rgb);
      end else begin
        if (tr_state != TR_IDLE) tr_state = TR_DONE;
        return make_vertex(zot_pkg::KindDone, 0, 0, 24'd0);
      end
    end
  endfunction

  function automatic void apply_item(zot_pkg::op_e op, int x, int y, logic [23:0] c);
    vertex_t v;
    case (op)
      zot_pkg::OP_WRITE: begin
        frame_mem[y * 256 + x] = c;
        writes_done++;
      end
      zot_pkg::OP_START: begin
        foreach (seen_mem[i]) seen_mem[i] = 1'b0;
        scan_c = 0; scan_r = 0; walk_c = 0; walk_r = 0; head = 0;
        zone_rgb = 24'd0; held_ok = 1'b0;
        tr_state = TR_SCAN;
      end
      zot_pkg::OP_FETCH: begin
        v = trace_fetch();
        last_kind = v.kind;
        if (v.kind == zot_pkg::KindFirst) outlines++;
        fetches++;
        vertex_q.push_back(v);
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Long output hold, counted down in cycles.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      rx_hold_on <= 1'b1;
    end else begin
      rx_hold_on <= 1'b0;
    end
  end

  // Output side: random stalls, the long hold, and the result check.
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (vertex_q.size() == 0) begin
        report("unexpected result kind", kind_o, -1);
      end else begin
        want = vertex_q.pop_front();
        if (kind_o !== want.kind) report("kind", kind_o, want.kind);
        if (vertex_x_o !== want.vx) report("vertex_x", vertex_x_o, want.vx);
        if (vertex_y_o !== want.vy) report("vertex_y", vertex_y_o, want.vy);
        if (zone_red_o !== want.r) report("zone_red", zone_red_o, want.r);
        if (zone_green_o !== want.g) report("zone_green", zone_green_o, want.g);
        if (zone_blue_o !== want.b) report("zone_blue", zone_blue_o, want.b);
      end
      rx_gap = no_idle ? 0 : $urandom_range(0, 7);
    end
    if (rx_hold_on) begin
      out_stall_i <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Offers one item and returns in the time step of its transfer; valid stays
  // high so a back-to-back item needs no second assignment in that step.
  task automatic send_item(zot_pkg::op_e op, int x = 0, int y = 0, logic [23:0] c = 24'd0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    pixel_x_i  <= x[7:0];
    pixel_y_i  <= y[7:0];
    {red_i, green_i, blue_i} <= c;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(op, x, y, c);
  endtask

  // Drops valid right at the last transfer and waits for the block to drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgWidth) reg_w = value;
    else reg_h = value;
  endtask

  // Black comes with the given percentage; the rest is mostly primaries.
  function automatic logic [23:0] pick_color(int black_pct);
    int sel;
    if ($urandom_range(0, 99) < black_pct) return 24'd0;
    sel = $urandom_range(0, 6);
    if (sel < 2) return 24'hFF0000;
    if (sel < 4) return 24'h00FF00;
    if (sel < 6) return 24'h0000FF;
    return 24'($urandom());
  endfunction

  task automatic fill_frame(int w, int h, int black_pct);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) send_item(zot_pkg::OP_WRITE, x, y, pick_color(black_pct));
  endtask

  // Fetches until the scan reports finished, then once more; some noise is
  // mixed in: no-ops and rewrites of pixels that are already loaded.
  task automatic fetch_all(int w, int h, bit noisy);
    int guard;
    guard = 0;
    do begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) send_item(zot_pkg::OP_NOP);
        else send_item(zot_pkg::OP_WRITE, $urandom_range(0, w - 1),
                       $urandom_range(0, h - 1), pick_color(30));
      end
      send_item(zot_pkg::OP_FETCH);
      guard++;
    end while (last_kind != zot_pkg::KindDone && guard < 20000);
    send_item(zot_pkg::OP_FETCH);
  endtask

  task automatic run_frame(int w_reg, int h_reg, bit noisy, int black_pct);
    int w, h;
    w = (w_reg > 256) ? 256 : w_reg;
    h = (h_reg > 256) ? 256 : h_reg;
    write_reg(CfgWidth, w_reg);
    write_reg(CfgHeight, h_reg);
    fill_frame(w, h, black_pct);
    send_item(zot_pkg::OP_START);
    fetch_all(w, h, noisy);
    drain();
  endtask

  task automatic test_fetch_before_start();
    send_item(zot_pkg::OP_FETCH);
    send_item(zot_pkg::OP_NOP);
    send_item(zot_pkg::OP_FETCH);
    drain();
  endtask

  task automatic test_empty_image();
    write_reg(CfgWidth, 0);
    write_reg(CfgHeight, 4);
    send_item(zot_pkg::OP_START);
    send_item(zot_pkg::OP_FETCH);
    send_item(zot_pkg::OP_FETCH);
    drain();
  endtask

  // A small cross with two-turn corners, then the width shrinks mid-scan.
  task automatic test_shrink_mid_scan();
    logic [23:0] c;
    write_reg(CfgWidth, 3);
    write_reg(CfgHeight, 3);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) begin
        c = ((x == 1) || (y == 1)) ? 24'hFFFFFF : 24'd0;
        send_item(zot_pkg::OP_WRITE, x, y, c);
      end
    send_item(zot_pkg::OP_WRITE, 255, 255, 24'h808080);
    send_item(zot_pkg::OP_START);
    send_item(zot_pkg::OP_FETCH);
    send_item(zot_pkg::OP_FETCH);
    drain();
    write_reg(CfgWidth, 1);
    fetch_all(1, 3, 1'b0);
    drain();
  endtask

  task automatic test_random_frames();
    run_frame(511, 1, 1'b1, 5);
    no_idle = 1'b1;
    run_frame(8, 8, 1'b1, 30);
    no_idle = 1'b0;
    run_frame($urandom_range(2, 12), $urandom_range(2, 12), 1'b1, 30);
    run_frame(1, 1, 1'b0, 30);
  endtask

  // The output holds off long enough that a fetch waits at the input.
  task automatic test_output_hold();
    write_reg(CfgWidth, 6);
    write_reg(CfgHeight, 6);
    fill_frame(6, 6, 30);
    send_item(zot_pkg::OP_START);
    no_idle = 1'b1;
    rx_hold = 400;
    fetch_all(6, 6, 1'b0);
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = zot_pkg::OP_NOP;
    pixel_x_i   = '0;
    pixel_y_i   = '0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CfgWidth;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fetch_before_start();
    test_empty_image();
    test_shrink_mid_scan();
    test_random_frames();
    test_output_hold();

    $display("tb: %0d pixel writes, %0d fetches, %0d zone outlines traced", writes_done,
             fetches, outlines);
    $display("tb: covered empty, single-pixel, full-width and small random frames");
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #100ms;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
